@@ rtl/bbd_pkg.sv @@
`timescale 1ns / 1ps

package bbd_pkg;

  localparam int unsigned PIX_W = 8;

  // The nine samples of a 3x3 neighborhood around the output pixel.
  typedef struct packed {
    logic [PIX_W-1:0] nw;
    logic [PIX_W-1:0] n;
    logic [PIX_W-1:0] ne;
    logic [PIX_W-1:0] w;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] e;
    logic [PIX_W-1:0] sw;
    logic [PIX_W-1:0] s;
    logic [PIX_W-1:0] se;
  } bbd_taps_t;

  // Frame borders that touch the output pixel, plus its mosaic phase.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic even_row;
    logic even_col;
  } bbd_edge_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             run_last;
    logic             frame_last;
  } bbd_result_t;

endpackage

@@ rtl/bbd_cell.sv @@
`timescale 1ns / 1ps

// One stage of the pixel chain: it takes its neighbor's sample on every shift.
module bbd_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [bbd_pkg::PIX_W-1:0] din,
  output logic [bbd_pkg::PIX_W-1:0] dout
);

  logic [bbd_pkg::PIX_W-1:0] sample;

  always_ff @(posedge clk) begin
    if (shift) begin
      sample <= din;
    end
  end

  assign dout = sample;

endmodule

@@ rtl/bbd_interp.sv @@
`timescale 1ns / 1ps

// Bilinear interpolation of one pixel from its masked 3x3 neighborhood.
module bbd_interp (
  input  bbd_pkg::bbd_taps_t        taps,
  input  bbd_pkg::bbd_edge_t        edges,
  output logic [bbd_pkg::PIX_W-1:0] red,
  output logic [bbd_pkg::PIX_W-1:0] green,
  output logic [bbd_pkg::PIX_W-1:0] blue
);

  logic [bbd_pkg::PIX_W-1:0] m_nw, m_n, m_ne, m_w, m_e, m_sw, m_s, m_se;
  logic [bbd_pkg::PIX_W:0]   pair_vert, pair_hor;
  logic [bbd_pkg::PIX_W+1:0] quad_cross, quad_diag;
  logic [bbd_pkg::PIX_W-1:0] avg_vert, avg_hor, avg_cross, avg_diag;

  // Samples outside the frame count as zero.
  always_comb begin
    m_n  = edges.top                  ? '0 : taps.n;
    m_s  = edges.bottom               ? '0 : taps.s;
    m_w  = edges.left                 ? '0 : taps.w;
    m_e  = edges.right                ? '0 : taps.e;
    m_nw = (edges.top || edges.left)     ? '0 : taps.nw;
    m_ne = (edges.top || edges.right)    ? '0 : taps.ne;
    m_sw = (edges.bottom || edges.left)  ? '0 : taps.sw;
    m_se = (edges.bottom || edges.right) ? '0 : taps.se;
  end

  always_comb begin
    pair_vert  = {1'b0, m_n} + {1'b0, m_s};
    pair_hor   = {1'b0, m_w} + {1'b0, m_e};
    quad_cross = {1'b0, pair_vert} + {1'b0, pair_hor};
    quad_diag  = ({2'b00, m_nw} + {2'b00, m_ne}) + ({2'b00, m_sw} + {2'b00, m_se});
    avg_vert  = pair_vert[bbd_pkg::PIX_W:1];
    avg_hor   = pair_hor[bbd_pkg::PIX_W:1];
    avg_cross = quad_cross[bbd_pkg::PIX_W+1:2];
    avg_diag  = quad_diag[bbd_pkg::PIX_W+1:2];
  end

  always_comb begin
    unique case ({edges.even_row, edges.even_col})
      2'b11: begin
        red = avg_vert;  green = taps.c;    blue = avg_hor;
      end
      2'b00: begin
        red = avg_hor;   green = taps.c;    blue = avg_vert;
      end
      2'b10: begin
        red = avg_diag;  green = avg_cross; blue = taps.c;
      end
      default: begin
        red = taps.c;    green = avg_cross; blue = avg_diag;
      end
    endcase
  end

endmodule

@@ rtl/bbd_skid.sv @@
`timescale 1ns / 1ps

// Two-entry result queue. Its room flag comes from a register, so the
// downstream stall never reaches the upstream side in the same cycle.
module bbd_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bbd_pkg::bbd_result_t din,
  output logic                 room,
  output bbd_pkg::bbd_result_t dout,
  output logic                 dout_valid,
  input  logic                 dout_stall
);

  bbd_pkg::bbd_result_t slot0, slot1;
  logic [1:0]           count;
  logic [1:0]           count_next;
  logic                 pop;

  assign pop        = (count != 2'd0) && !dout_stall;
  assign room       = (count != 2'd2);
  assign dout       = slot0;
  assign dout_valid = (count != 2'd0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

endmodule

@@ rtl/bayer_bilinear_demosaic.sv @@
`timescale 1ns / 1ps

// Bilinear Bayer demosaic for a square frame of IMAGE_SIDE x IMAGE_SIDE raw
// 8-bit pixels in raster order, green at even row and even column. Every
// pixel transfer shifts the sample into a chain of 2*IMAGE_SIDE+2 cells, and
// the 3x3 neighborhood of pixel p is read at fixed taps of that chain when
// pixel p+IMAGE_SIDE+1 arrives; samples outside the frame count as zero.
// The block takes one pixel per cycle unless pixel_stall is high. The
// first IMAGE_SIDE+1 pixels of a frame produce no result; afterwards each
// pixel produces one. The final pixel of a frame starts a flush that runs
// the chain on its own for IMAGE_SIDE+1 more results while pixel_stall is
// held. run_last marks the last result caused by one pixel transfer, and
// frame_last marks the result of the frame's final pixel. Results pass
// through a two-entry queue, so a single waiting result does not hold up
// input; the input stalls while both entries are occupied and during the
// flush.
module bayer_bilinear_demosaic #(
  parameter int unsigned IMAGE_SIDE = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic [bbd_pkg::PIX_W-1:0] raw_pixel,
  output logic                      rgb_valid,
  input  logic                      rgb_stall,
  output logic [bbd_pkg::PIX_W-1:0] red,
  output logic [bbd_pkg::PIX_W-1:0] green,
  output logic [bbd_pkg::PIX_W-1:0] blue,
  output logic                      run_last,
  output logic                      frame_last
);

  localparam int unsigned CHAIN_LEN = 2 * IMAGE_SIDE + 2;
  localparam int unsigned POS_W     = $clog2(IMAGE_SIDE);
  localparam int unsigned FL_W      = $clog2(IMAGE_SIDE + 2);
  localparam logic [POS_W-1:0] SIDE_LAST = POS_W'(IMAGE_SIDE - 1);

  // Raster position of the next input pixel, and of the next result.
  logic [POS_W-1:0] q_row, q_col;
  logic [POS_W-1:0] p_row, p_col;
  // Results still owed after the final pixel of a frame.
  logic [FL_W-1:0]  flush_cnt;

  logic                      flushing;
  logic                      room;
  logic                      in_accept;
  logic                      q_last;
  logic                      emit_normal;
  logic                      flush_step;
  logic                      push;
  logic                      shift;
  logic [bbd_pkg::PIX_W-1:0] chain_in;
  logic [bbd_pkg::PIX_W-1:0] chain [CHAIN_LEN];

  bbd_pkg::bbd_taps_t   taps;
  bbd_pkg::bbd_edge_t   edges;
  bbd_pkg::bbd_result_t result;
  bbd_pkg::bbd_result_t head;

  assign flushing    = (flush_cnt != '0);
  assign pixel_stall = flushing || !room;
  assign in_accept   = pixel_valid && !pixel_stall;
  assign q_last      = (q_row == SIDE_LAST) && (q_col == SIDE_LAST);

  // A pixel yields a result once its position reaches IMAGE_SIDE+1.
  assign emit_normal = in_accept &&
                       ((q_row > POS_W'(1)) || ((q_row == POS_W'(1)) && (q_col != '0)));
  assign flush_step  = flushing && room;
  assign push        = emit_normal || flush_step;
  assign shift       = in_accept || flush_step;

  // During the flush the shifted-in value lies below the frame and is masked.
  assign chain_in = flushing ? '0 : raw_pixel;

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
    if (k == 0) begin : g_head
      bbd_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .din  (chain_in),
        .dout (chain[k])
      );
    end else begin : g_body
      bbd_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .din  (chain[k-1]),
        .dout (chain[k])
      );
    end
  end

  // The incoming sample sits at position p+IMAGE_SIDE+1, cell k holds the
  // sample one older than cell k-1, so the center lies at cell IMAGE_SIDE.
  always_comb begin
    taps.se = chain_in;
    taps.s  = chain[0];
    taps.sw = chain[1];
    taps.e  = chain[IMAGE_SIDE-1];
    taps.c  = chain[IMAGE_SIDE];
    taps.w  = chain[IMAGE_SIDE+1];
    taps.ne = chain[2*IMAGE_SIDE-1];
    taps.n  = chain[2*IMAGE_SIDE];
    taps.nw = chain[2*IMAGE_SIDE+1];
  end

  always_comb begin
    edges.top      = (p_row == '0);
    edges.bottom   = (p_row == SIDE_LAST);
    edges.left     = (p_col == '0);
    edges.right    = (p_col == SIDE_LAST);
    edges.even_row = !p_row[0];
    edges.even_col = !p_col[0];
  end

  bbd_interp u_interp (
    .taps (taps),
    .edges(edges),
    .red  (result.red),
    .green(result.green),
    .blue (result.blue)
  );

  // The final pixel's own result and all but the last flush result are not
  // the last of their transfer.
  assign result.run_last   = flushing ? (flush_cnt == FL_W'(1)) : !q_last;
  assign result.frame_last = flushing && (flush_cnt == FL_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      q_row <= '0;
      q_col <= '0;
    end else if (in_accept) begin
      if (q_col == SIDE_LAST) begin
        q_col <= '0;
        q_row <= (q_row == SIDE_LAST) ? '0 : q_row + POS_W'(1);
      end else begin
        q_col <= q_col + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_row <= '0;
      p_col <= '0;
    end else if (push) begin
      if (p_col == SIDE_LAST) begin
        p_col <= '0;
        p_row <= (p_row == SIDE_LAST) ? '0 : p_row + POS_W'(1);
      end else begin
        p_col <= p_col + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_cnt <= '0;
    end else if (in_accept && q_last) begin
      flush_cnt <= FL_W'(IMAGE_SIDE + 1);
    end else if (flush_step) begin
      flush_cnt <= flush_cnt - FL_W'(1);
    end
  end

  bbd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (result),
    .room      (room),
    .dout      (head),
    .dout_valid(rgb_valid),
    .dout_stall(rgb_stall)
  );

  assign red        = head.red;
  assign green      = head.green;
  assign blue       = head.blue;
  assign run_last   = head.run_last;
  assign frame_last = head.frame_last;

  // The frame's final result always closes its transfer.
  a_frame_last_closes: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && frame_last |-> run_last)
    else $error("frame_last result without run_last");

  // No pixel may enter while the flush is still running the chain.
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (rst)
    flushing |-> pixel_stall)
    else $error("pixel transfer allowed during flush");

  // The final pixel of a frame arms a flush of IMAGE_SIDE+1 results.
  a_flush_armed: assert property (@(posedge clk) disable iff (rst)
    in_accept && q_last |=> flush_cnt == FL_W'(IMAGE_SIDE + 1))
    else $error("flush not armed after final pixel");

  // The result column trails the input column by exactly one place.
  a_result_column: assert property (@(posedge clk) disable iff (rst)
    emit_normal |-> p_col == ((q_col == '0) ? SIDE_LAST : q_col - POS_W'(1)))
    else $error("result position out of step with input position");

endmodule
